/* hdl/dct_pkg.sv */
// dual countdown timer controller: shared types, constants and edit helpers
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps

package dct_pkg;

    localparam int unsigned MINUTE_LIMIT = 30;
    localparam int unsigned MIN_W        = 5;
    localparam int unsigned SEC_W        = 6;
    localparam int unsigned CNT_W        = 8;
    localparam int unsigned FIFO_DEPTH   = 2;
    localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [MIN_W-1:0] MIN_MAX        = MIN_W'(MINUTE_LIMIT - 1);
    localparam logic [SEC_W-1:0] SEC_MAX        = SEC_W'(59);
    localparam logic [SEC_W-1:0] SEC_STEP       = SEC_W'(10);
    localparam logic [SEC_W-1:0] SEC_EDIT_TOP   = SEC_W'(50);
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(20);

    typedef enum logic [1:0] {
        MODE_CHOOSE,
        MODE_EDIT,
        MODE_CONFIRM,
        MODE_ALARM
    } t_menu_mode;

    typedef enum logic [1:0] {
        FIELD_MIN_A,
        FIELD_SEC_A,
        FIELD_MIN_B,
        FIELD_SEC_B
    } t_field;

    typedef enum logic [1:0] {
        TONE_OFF,
        TONE_A,
        TONE_B
    } t_tone;

    // classified request handed from front to back
    typedef struct packed {
        logic is_tick;
        logic sel_ev;
        logic ent_ev;
    } t_cmd;

    typedef struct packed {
        logic             select_event;
        logic             enter_event;
        t_menu_mode       menu_mode;
        t_field           field_index;
        logic [MIN_W-1:0] minutes_a;
        logic [SEC_W-1:0] seconds_a;
        logic [MIN_W-1:0] minutes_b;
        logic [SEC_W-1:0] seconds_b;
        logic             running_a;
        logic             running_b;
        t_tone            tone;
        logic             tick_enable;
    } t_result;

    function automatic logic [MIN_W-1:0] edit_minutes(input logic [MIN_W-1:0] m,
                                                      input logic running);
        logic [MIN_W-1:0] res;
        if (m < MIN_MAX) begin
            res = m + MIN_W'(1);
        end else if (running) begin
            res = m;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    function automatic logic [SEC_W-1:0] edit_seconds(input logic [SEC_W-1:0] s,
                                                      input logic running);
        logic [SEC_W-1:0] res;
        if (s < SEC_EDIT_TOP) begin
            res = s + SEC_STEP;
        end else if (running || s < SEC_MAX) begin
            res = SEC_MAX;
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

/* hdl/dct_intf.sv */
// dual countdown timer controller: request, result and config channel interfaces
// depends on dct_pkg
`timescale 1ns / 1ps

interface dct_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic select_level;
    logic enter_level;

    modport source (output valid, output req_type, output select_level,
                    output enter_level, input ready);
    modport sink (input valid, input req_type, input select_level,
                  input enter_level, output ready);
endinterface

interface dct_out_if;
    logic                      valid;
    logic                      ready;
    logic                      select_event;
    logic                      enter_event;
    logic [1:0]                menu_mode;
    logic [1:0]                field_index;
    logic [dct_pkg::MIN_W-1:0] minutes_a;
    logic [dct_pkg::SEC_W-1:0] seconds_a;
    logic [dct_pkg::MIN_W-1:0] minutes_b;
    logic [dct_pkg::SEC_W-1:0] seconds_b;
    logic                      running_a;
    logic                      running_b;
    logic [1:0]                tone;
    logic                      tick_enable;

    modport source (output valid, output select_event, output enter_event,
                    output menu_mode, output field_index, output minutes_a,
                    output seconds_a, output minutes_b, output seconds_b,
                    output running_a, output running_b, output tone,
                    output tick_enable, input ready);
    modport sink (input valid, input select_event, input enter_event,
                  input menu_mode, input field_index, input minutes_a,
                  input seconds_a, input minutes_b, input seconds_b,
                  input running_a, input running_b, input tone,
                  input tick_enable, output ready);
endinterface

interface dct_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [dct_pkg::CNT_W-1:0] debounce_threshold;

    modport source (output valid, output debounce_threshold, input ready);
    modport sink (input valid, input debounce_threshold, output ready);
endinterface

/* hdl/dct_front.sv */
// dual countdown timer controller: front end, button debouncer and request classifier
// depends on dct_pkg and dct_intf; feeds dct_fifo
`timescale 1ns / 1ps

module dct_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dct_in_if.sink          i_in,
    dct_cfg_if.sink         i_cfg,
    output logic            o_cmd_valid,
    output dct_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_ready
);

    logic [dct_pkg::CNT_W-1:0] r_thr;
    logic                      r_sel_flag, r_ent_flag;
    logic [dct_pkg::CNT_W-1:0] r_sel_press, r_sel_rel, r_ent_press, r_ent_rel;

    logic                      n_sel_flag, n_ent_flag;
    logic [dct_pkg::CNT_W-1:0] n_sel_press, n_sel_rel, n_ent_press, n_ent_rel;
    logic [dct_pkg::CNT_W-1:0] sel_cnt, ent_cnt;
    logic                      ev_sel, ev_ent, sel_done;
    logic                      accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_cmd_ready;
    assign o_cmd_valid = i_in.valid;
    assign accept      = i_in.valid && i_cmd_ready;

    always_comb begin
        n_sel_flag  = r_sel_flag;
        n_ent_flag  = r_ent_flag;
        n_sel_press = r_sel_press;
        n_sel_rel   = r_sel_rel;
        n_ent_press = r_ent_press;
        n_ent_rel   = r_ent_rel;
        ev_sel      = 1'b0;
        ev_ent      = 1'b0;
        sel_done    = 1'b0;
        sel_cnt     = '0;
        ent_cnt     = '0;
        // select first; an accepted select press skips enter for this sample
        if (!r_sel_flag) begin
            sel_cnt = i_in.select_level ? '0 : r_sel_press + dct_pkg::CNT_W'(1);
            if (sel_cnt > r_thr) begin
                n_sel_press = '0;
                n_sel_flag  = 1'b1;
                ev_sel      = 1'b1;
                ev_ent      = r_ent_flag;
                sel_done    = 1'b1;
            end else begin
                n_sel_press = sel_cnt;
            end
        end else begin
            sel_cnt = i_in.select_level ? r_sel_rel + dct_pkg::CNT_W'(1) : '0;
            if (sel_cnt > r_thr) begin
                n_sel_rel  = '0;
                n_sel_flag = 1'b0;
            end else begin
                n_sel_rel = sel_cnt;
            end
        end
        if (!sel_done) begin
            if (!r_ent_flag) begin
                ent_cnt = i_in.enter_level ? '0 : r_ent_press + dct_pkg::CNT_W'(1);
                if (ent_cnt > r_thr) begin
                    n_ent_press = '0;
                    n_ent_flag  = 1'b1;
                    ev_ent      = 1'b1;
                    ev_sel      = n_sel_flag;
                end else begin
                    n_ent_press = ent_cnt;
                end
            end else begin
                ent_cnt = i_in.enter_level ? r_ent_rel + dct_pkg::CNT_W'(1) : '0;
                if (ent_cnt > r_thr) begin
                    n_ent_rel  = '0;
                    n_ent_flag = 1'b0;
                end else begin
                    n_ent_rel = ent_cnt;
                end
            end
        end
    end

    always_comb begin
        o_cmd.is_tick = i_in.req_type;
        o_cmd.sel_ev  = !i_in.req_type && ev_sel;
        o_cmd.ent_ev  = !i_in.req_type && ev_ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= dct_pkg::DEBOUNCE_RESET;
            r_sel_flag  <= 1'b0;
            r_ent_flag  <= 1'b0;
            r_sel_press <= '0;
            r_sel_rel   <= '0;
            r_ent_press <= '0;
            r_ent_rel   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_thr <= i_cfg.debounce_threshold;
            end
            if (accept && !i_in.req_type) begin
                r_sel_flag  <= n_sel_flag;
                r_ent_flag  <= n_ent_flag;
                r_sel_press <= n_sel_press;
                r_sel_rel   <= n_sel_rel;
                r_ent_press <= n_ent_press;
                r_ent_rel   <= n_ent_rel;
            end
        end
    end

endmodule

/* hdl/dct_fifo.sv */
// dual countdown timer controller: short request queue between front and back
// depends on dct_pkg
`timescale 1ns / 1ps

module dct_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  dct_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output dct_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop_ready
);

    dct_pkg::t_cmd                     r_mem [dct_pkg::FIFO_DEPTH];
    logic [dct_pkg::FIFO_PTR_W-1:0]    r_wptr, r_rptr;
    logic [dct_pkg::FIFO_CNT_W-1:0]    r_count;
    logic                              push, pop;

    assign o_push_ready = r_count < dct_pkg::FIFO_CNT_W'(dct_pkg::FIFO_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_cmd    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == dct_pkg::FIFO_PTR_W'(dct_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_wptr + dct_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == dct_pkg::FIFO_PTR_W'(dct_pkg::FIFO_DEPTH - 1))
                          ? '0 : r_rptr + dct_pkg::FIFO_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + dct_pkg::FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - dct_pkg::FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dct_pkg::FIFO_CNT_W'(dct_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* hdl/dct_back.sv */
// dual countdown timer controller: back end, menu, countdown and result register
// depends on dct_pkg and dct_intf; drained from dct_fifo
`timescale 1ns / 1ps

module dct_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  dct_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    dct_out_if.source     o_out
);

    dct_pkg::t_menu_mode       r_mode, n_mode;
    dct_pkg::t_field           r_field, n_field;
    logic [dct_pkg::MIN_W-1:0] r_min_a, r_min_b, n_min_a, n_min_b;
    logic [dct_pkg::SEC_W-1:0] r_sec_a, r_sec_b, n_sec_a, n_sec_b;
    logic [1:0]                r_run, n_run;
    dct_pkg::t_tone            r_tone, n_tone;
    logic                      r_tick_en, n_tick_en;
    dct_pkg::t_result          r_res, n_res;
    logic                      r_out_valid;

    logic                      pop, press, tick_go, hit_a, hit_b;
    logic [dct_pkg::MIN_W-1:0] cd_min_a, cd_min_b;
    logic [dct_pkg::SEC_W-1:0] cd_sec_a, cd_sec_b;
    logic                      cd_zero_a, cd_zero_b;
    logic                      nz_a, nz_b;
    logic [1:0]                conf_run;

    assign o_cmd_ready = !r_out_valid || o_out.ready;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign press       = !i_cmd.is_tick && (i_cmd.sel_ev || i_cmd.ent_ev);
    assign tick_go     = i_cmd.is_tick && r_tick_en;
    assign nz_a        = (r_min_a != '0) || (r_sec_a != '0);
    assign nz_b        = (r_min_b != '0) || (r_sec_b != '0);

    // one second down per channel
    always_comb begin
        if (r_sec_a == '0 && r_min_a != '0) begin
            cd_min_a  = r_min_a - dct_pkg::MIN_W'(1);
            cd_sec_a  = dct_pkg::SEC_MAX;
            cd_zero_a = 1'b0;
        end else begin
            cd_min_a  = r_min_a;
            cd_sec_a  = (r_sec_a != '0) ? r_sec_a - dct_pkg::SEC_W'(1) : r_sec_a;
            cd_zero_a = (cd_sec_a == '0) && (r_min_a == '0);
        end
        if (r_sec_b == '0 && r_min_b != '0) begin
            cd_min_b  = r_min_b - dct_pkg::MIN_W'(1);
            cd_sec_b  = dct_pkg::SEC_MAX;
            cd_zero_b = 1'b0;
        end else begin
            cd_min_b  = r_min_b;
            cd_sec_b  = (r_sec_b != '0) ? r_sec_b - dct_pkg::SEC_W'(1) : r_sec_b;
            cd_zero_b = (cd_sec_b == '0) && (r_min_b == '0);
        end
    end

    assign hit_a = tick_go && r_run[0] && cd_zero_a;
    assign hit_b = tick_go && r_run[1] && cd_zero_b;

    // start/stop; the minute fields also link the other channel
    always_comb begin
        conf_run = r_run;
        unique case (r_field)
            dct_pkg::FIELD_MIN_A: begin
                conf_run[0] = nz_a && !r_run[0];
                conf_run[1] = nz_b && conf_run[0];
            end
            dct_pkg::FIELD_SEC_A: begin
                conf_run[0] = nz_a && !r_run[0];
            end
            dct_pkg::FIELD_MIN_B: begin
                conf_run[1] = nz_b && !r_run[1];
                conf_run[0] = nz_a && conf_run[1];
            end
            dct_pkg::FIELD_SEC_B: begin
                conf_run[1] = nz_b && !r_run[1];
            end
            default: conf_run = r_run;
        endcase
    end

    // menu mode next state
    always_comb begin
        n_mode = r_mode;
        if (i_cmd.is_tick) begin
            if (hit_a || hit_b) begin
                n_mode = dct_pkg::MODE_ALARM;
            end
        end else if (press) begin
            unique case (r_mode)
                dct_pkg::MODE_CHOOSE: begin
                    if (i_cmd.ent_ev) begin
                        n_mode = dct_pkg::MODE_EDIT;
                    end
                end
                dct_pkg::MODE_EDIT: begin
                    if (i_cmd.ent_ev) begin
                        n_mode = dct_pkg::MODE_CONFIRM;
                    end
                end
                dct_pkg::MODE_CONFIRM: n_mode = dct_pkg::MODE_CHOOSE;
                dct_pkg::MODE_ALARM:   n_mode = dct_pkg::MODE_CHOOSE;
                default:               n_mode = r_mode;
            endcase
        end
    end

    // timer datapath
    always_comb begin
        n_field   = r_field;
        n_min_a   = r_min_a;
        n_sec_a   = r_sec_a;
        n_min_b   = r_min_b;
        n_sec_b   = r_sec_b;
        n_run     = r_run;
        n_tone    = r_tone;
        n_tick_en = r_tick_en;
        if (tick_go) begin
            if (r_run[0]) begin
                n_min_a = cd_min_a;
                n_sec_a = cd_sec_a;
            end
            if (r_run[1]) begin
                n_min_b = cd_min_b;
                n_sec_b = cd_sec_b;
            end
            n_run = r_run & ~{hit_b, hit_a};
            if (hit_b) begin
                n_tone = dct_pkg::TONE_B;
            end else if (hit_a) begin
                n_tone = dct_pkg::TONE_A;
            end
            if (n_run == 2'b00) begin
                n_tick_en = 1'b0;
            end
        end else if (press) begin
            unique case (r_mode)
                dct_pkg::MODE_CHOOSE: begin
                    if (i_cmd.sel_ev) begin
                        n_field = dct_pkg::t_field'(r_field + 2'd1);
                    end
                end
                dct_pkg::MODE_EDIT: begin
                    if (i_cmd.sel_ev) begin
                        unique case (r_field)
                            dct_pkg::FIELD_MIN_A:
                                n_min_a = dct_pkg::edit_minutes(r_min_a, r_run[0]);
                            dct_pkg::FIELD_SEC_A:
                                n_sec_a = dct_pkg::edit_seconds(r_sec_a, r_run[0]);
                            dct_pkg::FIELD_MIN_B:
                                n_min_b = dct_pkg::edit_minutes(r_min_b, r_run[1]);
                            dct_pkg::FIELD_SEC_B:
                                n_sec_b = dct_pkg::edit_seconds(r_sec_b, r_run[1]);
                            default: n_min_a = r_min_a;
                        endcase
                    end
                end
                dct_pkg::MODE_CONFIRM: begin
                    if (i_cmd.ent_ev) begin
                        n_run     = conf_run;
                        n_tick_en = conf_run != 2'b00;
                    end
                end
                dct_pkg::MODE_ALARM: n_tone = dct_pkg::TONE_OFF;
                default:             n_tone = r_tone;
            endcase
        end
    end

    always_comb begin
        n_res.select_event = i_cmd.sel_ev;
        n_res.enter_event  = i_cmd.ent_ev;
        n_res.menu_mode    = n_mode;
        n_res.field_index  = n_field;
        n_res.minutes_a    = n_min_a;
        n_res.seconds_a    = n_sec_a;
        n_res.minutes_b    = n_min_b;
        n_res.seconds_b    = n_sec_b;
        n_res.running_a    = n_run[0];
        n_res.running_b    = n_run[1];
        n_res.tone         = n_tone;
        n_res.tick_enable  = n_tick_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= dct_pkg::MODE_CHOOSE;
            r_field     <= dct_pkg::FIELD_MIN_A;
            r_min_a     <= '0;
            r_sec_a     <= '0;
            r_min_b     <= '0;
            r_sec_b     <= '0;
            r_run       <= '0;
            r_tone      <= dct_pkg::TONE_OFF;
            r_tick_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_mode      <= n_mode;
                r_field     <= n_field;
                r_min_a     <= n_min_a;
                r_sec_a     <= n_sec_a;
                r_min_b     <= n_min_b;
                r_sec_b     <= n_sec_b;
                r_run       <= n_run;
                r_tone      <= n_tone;
                r_tick_en   <= n_tick_en;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.select_event = r_res.select_event;
    assign o_out.enter_event  = r_res.enter_event;
    assign o_out.menu_mode    = r_res.menu_mode;
    assign o_out.field_index  = r_res.field_index;
    assign o_out.minutes_a    = r_res.minutes_a;
    assign o_out.seconds_a    = r_res.seconds_a;
    assign o_out.minutes_b    = r_res.minutes_b;
    assign o_out.seconds_b    = r_res.seconds_b;
    assign o_out.running_a    = r_res.running_a;
    assign o_out.running_b    = r_res.running_b;
    assign o_out.tone         = r_res.tone;
    assign o_out.tick_enable  = r_res.tick_enable;

    a_tone_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tone != dct_pkg::TONE_OFF) == (r_mode == dct_pkg::MODE_ALARM))
        else $error("tone and alarm mode disagree");

    a_tick_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick_en == (r_run != 2'b00))
        else $error("tick enable out of step with run flags");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_a <= dct_pkg::MIN_MAX && r_min_b <= dct_pkg::MIN_MAX &&
        r_sec_a <= dct_pkg::SEC_MAX && r_sec_b <= dct_pkg::SEC_MAX)
        else $error("time register out of range");

endmodule

/* hdl/dual_countdown_timer_controller_unit.sv */
// dual countdown timer controller: top level joining front, queue and back
// depends on dct_pkg, dct_intf, dct_front, dct_fifo, dct_back
//
// channel   dir   handshake      contents
// i_in      in    valid/ready    req_type, select_level, enter_level
// i_cfg     in    valid/ready    debounce_threshold (always ready)
// o_out     out   valid/ready    events, mode, field, times, run flags, tone, tick enable
//
// one request per cycle sustained while o_out is ready; a taken request goes into a
// two-entry queue, and the back pops it and loads its result into the result register
// reset is synchronous and active low; no clearing pass
// a stalled result holds the back, the queue then fills and drops i_in.ready
`timescale 1ns / 1ps

module dual_countdown_timer_controller_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dct_in_if.sink    i_in,
    dct_cfg_if.sink   i_cfg,
    dct_out_if.source o_out
);

    logic          front_valid, front_ready;
    dct_pkg::t_cmd front_cmd;
    logic          back_valid, back_ready;
    dct_pkg::t_cmd back_cmd;

    dct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    dct_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_cmd    (back_cmd),
        .i_pop_ready  (back_ready)
    );

    dct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .i_cmd       (back_cmd),
        .o_cmd_ready (back_ready),
        .o_out       (o_out)
    );

endmodule

/* verif/tb_dual_countdown_timer_controller_unit.sv */
// testbench for the dual countdown timer controller: a directed table, then random
// button presses, noise and second ticks, each result checked against the table or a local predictor
// depends on dct_pkg, dct_intf and dual_countdown_timer_controller_unit
`timescale 1ns / 1ps

module tb_dual_countdown_timer_controller_unit;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PLAN_ROWS    = 14;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;
    localparam logic LVL_DN     = 1'b0;
    localparam logic LVL_UP     = 1'b1;

    localparam logic [dct_pkg::MIN_W-1:0] MIN_LAST =
        dct_pkg::MIN_W'(dct_pkg::MINUTE_LIMIT - 1);
    localparam logic [dct_pkg::SEC_W-1:0] SEC_LAST       = dct_pkg::SEC_W'(59);
    localparam logic [dct_pkg::SEC_W-1:0] SEC_JUMP       = dct_pkg::SEC_W'(10);
    localparam logic [dct_pkg::SEC_W-1:0] SEC_JUMP_BELOW = dct_pkg::SEC_W'(50);
    localparam logic [7:0]       THR_AT_RESET   = 8'd20;
    localparam logic [7:0]       THR_MIN        = 8'd1;
    localparam logic [7:0]       THR_MAX        = 8'd255;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic             is_tick;
        logic             sel_lvl;
        logic             ent_lvl;
        int               reps;
        logic [7:0]       thr;
        logic             typed;
        dct_pkg::t_result want;
    } t_plan_row;

    logic clk = 1'b0;
    logic rst_n;

    dct_in_if  req_ch();
    dct_cfg_if cfg_ch();
    dct_out_if res_ch();

    dual_countdown_timer_controller_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    always #2 clk = ~clk;

    // press/release walk to a running channel A, its alarm, the acknowledge,
    // then a threshold that never accepts a level change
    t_plan_row plan [PLAN_ROWS] = '{
        '{ROW_REQ, REQ_TICK,   LVL_UP, LVL_UP, 1,  8'd0,    1'b1, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_DN, LVL_DN, 1,  8'd0,    1'b1, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_UP, LVL_UP, 1,  8'd0,    1'b1, '0},
        '{ROW_CFG, REQ_SAMPLE, LVL_UP, LVL_UP, 0,  THR_MIN, 1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_DN, LVL_UP, 2,  8'd0,    1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_UP, LVL_DN, 2,  8'd0,    1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_DN, LVL_UP, 2,  8'd0,    1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_UP, LVL_UP, 1,  8'd0,    1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_UP, LVL_DN, 2,  8'd0,    1'b0, '0},
        '{ROW_REQ, REQ_TICK,   LVL_DN, LVL_DN, 10, 8'd0,    1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_UP, LVL_UP, 1,  8'd0,    1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_DN, LVL_UP, 2,  8'd0,    1'b0, '0},
        '{ROW_CFG, REQ_SAMPLE, LVL_UP, LVL_UP, 0,  THR_MAX, 1'b0, '0},
        '{ROW_REQ, REQ_SAMPLE, LVL_DN, LVL_DN, 3,  8'd0,    1'b0, '0}
    };

    // predicted timer state
    logic [1:0]                btn_held;
    logic [7:0]                sel_dn_cnt, sel_up_cnt, ent_dn_cnt, ent_up_cnt;
    logic [7:0]                dbnc_limit;
    dct_pkg::t_menu_mode       menu_st;
    dct_pkg::t_field           fld;
    logic [dct_pkg::MIN_W-1:0] mn_a, mn_b;
    logic [dct_pkg::SEC_W-1:0] sc_a, sc_b;
    logic [1:0]                run_ab;
    dct_pkg::t_tone            buzz;
    logic                      tick_on;

    dct_pkg::t_result state_after_q [$];
    logic             note_typed;
    dct_pkg::t_result note_want;
    int      fail_count   = 0;
    int      result_idx   = 0;
    int      cycle_count  = 0;
    int      issued_total = 0;
    int      src_gap_pct  = 0;
    int      stall_pct    = 0;
    int      sink_hold    = 0;

    function automatic void clear_timer_model();
        btn_held   = '0;
        sel_dn_cnt = '0;
        sel_up_cnt = '0;
        ent_dn_cnt = '0;
        ent_up_cnt = '0;
        dbnc_limit = THR_AT_RESET;
        menu_st    = dct_pkg::MODE_CHOOSE;
        fld        = dct_pkg::FIELD_MIN_A;
        mn_a       = '0;
        sc_a       = '0;
        mn_b       = '0;
        sc_b       = '0;
        run_ab     = '0;
        buzz       = dct_pkg::TONE_OFF;
        tick_on    = 1'b0;
    endfunction

    function automatic logic [dct_pkg::MIN_W-1:0] bump_minutes(
        input logic [dct_pkg::MIN_W-1:0] m, input logic running);
        return (m < MIN_LAST) ? m + dct_pkg::MIN_W'(1) : (running ? m : '0);
    endfunction

    function automatic logic [dct_pkg::SEC_W-1:0] bump_seconds(
        input logic [dct_pkg::SEC_W-1:0] s, input logic running);
        logic [dct_pkg::SEC_W-1:0] nxt;
        if (s < SEC_JUMP_BELOW) begin
            nxt = s + SEC_JUMP;
        end else if (running || s < SEC_LAST) begin
            nxt = SEC_LAST;
        end else begin
            nxt = '0;
        end
        return nxt;
    endfunction

    // one second off a channel, true once it sits at 0:00
    function automatic logic count_one(inout logic [dct_pkg::MIN_W-1:0] m,
                                       inout logic [dct_pkg::SEC_W-1:0] s);
        logic expired;
        expired = 1'b0;
        if (s == 0 && m > 0) begin
            s = SEC_LAST;
            m = m - dct_pkg::MIN_W'(1);
        end else begin
            if (s > 0) s = s - dct_pkg::SEC_W'(1);
            expired = (s == 0 && m == 0);
        end
        return expired;
    endfunction

    function automatic void apply_press(input logic [1:0] ev);
        logic ra, rb, nza, nzb;
        ra  = run_ab[0];
        rb  = run_ab[1];
        nza = (mn_a != 0) || (sc_a != 0);
        nzb = (mn_b != 0) || (sc_b != 0);
        case (menu_st)
            dct_pkg::MODE_CHOOSE: begin
                if (ev[0]) fld = dct_pkg::t_field'(fld + 2'd1);
                if (ev[1]) menu_st = dct_pkg::MODE_EDIT;
            end
            dct_pkg::MODE_EDIT: begin
                if (ev[0]) begin
                    case (fld)
                        dct_pkg::FIELD_MIN_A: mn_a = bump_minutes(mn_a, ra);
                        dct_pkg::FIELD_SEC_A: sc_a = bump_seconds(sc_a, ra);
                        dct_pkg::FIELD_MIN_B: mn_b = bump_minutes(mn_b, rb);
                        default:              sc_b = bump_seconds(sc_b, rb);
                    endcase
                end
                if (ev[1]) menu_st = dct_pkg::MODE_CONFIRM;
            end
            dct_pkg::MODE_CONFIRM: begin
                if (ev[0]) menu_st = dct_pkg::MODE_CHOOSE;
                if (ev[1]) begin
                    // minute fields start or stop both channels together
                    case (fld)
                        dct_pkg::FIELD_MIN_A: begin
                            ra = nza ? !ra : 1'b0;
                            rb = nzb ? ra : 1'b0;
                        end
                        dct_pkg::FIELD_SEC_A: ra = nza ? !ra : 1'b0;
                        dct_pkg::FIELD_MIN_B: begin
                            rb = nzb ? !rb : 1'b0;
                            ra = nza ? rb : 1'b0;
                        end
                        default: rb = nzb ? !rb : 1'b0;
                    endcase
                    run_ab  = {rb, ra};
                    tick_on = |run_ab;
                    menu_st = dct_pkg::MODE_CHOOSE;
                end
            end
            default: begin
                buzz    = dct_pkg::TONE_OFF;
                menu_st = dct_pkg::MODE_CHOOSE;
            end
        endcase
    endfunction

    function automatic dct_pkg::t_result predict_request(input logic is_tick,
                                                         input logic s_lvl,
                                                         input logic e_lvl);
        logic [1:0]       ev;
        logic             sel_taken;
        dct_pkg::t_result r;
        ev        = '0;
        sel_taken = 1'b0;
        if (is_tick == REQ_SAMPLE) begin
            if (!btn_held[0]) begin
                sel_dn_cnt = (s_lvl == LVL_DN) ? sel_dn_cnt + 8'd1 : 8'd0;
                if (sel_dn_cnt > dbnc_limit) begin
                    sel_dn_cnt  = '0;
                    btn_held[0] = 1'b1;
                    ev          = btn_held;
                    sel_taken   = 1'b1;
                end
            end else begin
                sel_up_cnt = (s_lvl == LVL_UP) ? sel_up_cnt + 8'd1 : 8'd0;
                if (sel_up_cnt > dbnc_limit) begin
                    sel_up_cnt  = '0;
                    btn_held[0] = 1'b0;
                end
            end
            // a select press ends the sample before enter is looked at
            if (!sel_taken) begin
                if (!btn_held[1]) begin
                    ent_dn_cnt = (e_lvl == LVL_DN) ? ent_dn_cnt + 8'd1 : 8'd0;
                    if (ent_dn_cnt > dbnc_limit) begin
                        ent_dn_cnt  = '0;
                        btn_held[1] = 1'b1;
                        ev          = btn_held;
                    end
                end else begin
                    ent_up_cnt = (e_lvl == LVL_UP) ? ent_up_cnt + 8'd1 : 8'd0;
                    if (ent_up_cnt > dbnc_limit) begin
                        ent_up_cnt  = '0;
                        btn_held[1] = 1'b0;
                    end
                end
            end
            if (ev != 0) apply_press(ev);
        end else if (tick_on) begin
            if (run_ab[0]) begin
                if (count_one(mn_a, sc_a)) begin
                    buzz      = dct_pkg::TONE_A;
                    run_ab[0] = 1'b0;
                    menu_st   = dct_pkg::MODE_ALARM;
                end
            end
            if (run_ab[1]) begin
                if (count_one(mn_b, sc_b)) begin
                    buzz      = dct_pkg::TONE_B;
                    run_ab[1] = 1'b0;
                    menu_st   = dct_pkg::MODE_ALARM;
                end
            end
            if (run_ab == 0) tick_on = 1'b0;
        end
        r.select_event = ev[0];
        r.enter_event  = ev[1];
        r.menu_mode    = menu_st;
        r.field_index  = fld;
        r.minutes_a    = mn_a;
        r.seconds_a    = sc_a;
        r.minutes_b    = mn_b;
        r.seconds_b    = sc_b;
        r.running_a    = run_ab[0];
        r.running_b    = run_ab[1];
        r.tone         = buzz;
        r.tick_enable  = tick_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                   input logic [7:0] want_v);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 result_idx, what, got_v, want_v);
        fail_count++;
    endtask

    task automatic check_panel(input dct_pkg::t_result got, input dct_pkg::t_result want);
        if (got.select_event !== want.select_event)
            report_mismatch("select_event", got.select_event, want.select_event);
        if (got.enter_event !== want.enter_event)
            report_mismatch("enter_event", got.enter_event, want.enter_event);
        if (got.menu_mode !== want.menu_mode)
            report_mismatch("menu_mode", got.menu_mode, want.menu_mode);
        if (got.field_index !== want.field_index)
            report_mismatch("field_index", got.field_index, want.field_index);
        if (got.minutes_a !== want.minutes_a)
            report_mismatch("minutes_a", got.minutes_a, want.minutes_a);
        if (got.seconds_a !== want.seconds_a)
            report_mismatch("seconds_a", got.seconds_a, want.seconds_a);
        if (got.minutes_b !== want.minutes_b)
            report_mismatch("minutes_b", got.minutes_b, want.minutes_b);
        if (got.seconds_b !== want.seconds_b)
            report_mismatch("seconds_b", got.seconds_b, want.seconds_b);
        if (got.running_a !== want.running_a)
            report_mismatch("running_a", got.running_a, want.running_a);
        if (got.running_b !== want.running_b)
            report_mismatch("running_b", got.running_b, want.running_b);
        if (got.tone !== want.tone)
            report_mismatch("tone", got.tone, want.tone);
        if (got.tick_enable !== want.tick_enable)
            report_mismatch("tick_enable", got.tick_enable, want.tick_enable);
    endtask

    // results are checked before the request of the same edge is predicted
    always @(posedge clk) begin
        dct_pkg::t_result got;
        dct_pkg::t_result pred;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got = dct_pkg::t_result'({res_ch.select_event, res_ch.enter_event,
                                          res_ch.menu_mode, res_ch.field_index,
                                          res_ch.minutes_a, res_ch.seconds_a,
                                          res_ch.minutes_b, res_ch.seconds_b,
                                          res_ch.running_a, res_ch.running_b,
                                          res_ch.tone, res_ch.tick_enable});
                if (state_after_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 8'd0, 8'd0);
                end else begin
                    check_panel(got, state_after_q.pop_front());
                end
                result_idx++;
            end
            if (cfg_ch.valid && cfg_ch.ready) dbnc_limit = cfg_ch.debounce_threshold;
            if (req_ch.valid && req_ch.ready) begin
                pred = predict_request(req_ch.req_type, req_ch.select_level,
                                       req_ch.enter_level);
                state_after_q.push_back(note_typed ? note_want : pred);
            end
        end
    end

    // result side stalls in bursts
    always @(posedge clk) begin
        if (sink_hold > 0) begin
            sink_hold      <= sink_hold - 1;
            res_ch.ready   <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            sink_hold      <= $urandom_range(0, 13);
            res_ch.ready   <= 1'b0;
        end else begin
            res_ch.ready   <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("dual_countdown_timer_controller_unit test failed");
            $finish;
        end
    end

    task automatic send_request(input logic is_tick, input logic s_lvl, input logic e_lvl,
                                input logic typed, input dct_pkg::t_result want);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= is_tick;
        req_ch.select_level <= s_lvl;
        req_ch.enter_level  <= e_lvl;
        note_typed          <= typed;
        note_want           <= want;
        do @(posedge clk); while (!req_ch.ready);
        issued_total++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (state_after_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [7:0] thr);
        cfg_ch.valid              <= 1'b1;
        cfg_ch.debounce_threshold <= thr;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic hold_levels(input logic s_lvl, input logic e_lvl, input int n);
        repeat (n) send_request(REQ_SAMPLE, s_lvl, e_lvl, 1'b0, '0);
    endtask

    initial begin
        int         i;
        int         k;
        int         phase;
        int         goal;
        int         r;
        int         b;
        int         n;
        int         settle;
        logic [7:0] thr;
        logic       s_lvl;
        logic       e_lvl;

        rst_n                     <= 1'b0;
        req_ch.valid              <= 1'b0;
        req_ch.req_type           <= REQ_SAMPLE;
        req_ch.select_level       <= LVL_UP;
        req_ch.enter_level        <= LVL_UP;
        cfg_ch.valid              <= 1'b0;
        cfg_ch.debounce_threshold <= THR_AT_RESET;
        note_typed                <= 1'b0;
        note_want                 <= '0;
        clear_timer_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gap_pct = 20;
        stall_pct   = 20;
        for (i = 0; i < PLAN_ROWS; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                drain_results();
                write_threshold(plan[i].thr);
            end else begin
                for (k = 0; k < plan[i].reps; k++) begin
                    send_request(plan[i].is_tick, plan[i].sel_lvl, plan[i].ent_lvl,
                                 plan[i].typed, plan[i].want);
                end
            end
        end

        issued_total = 0;
        phase        = 0;
        while (issued_total < RANDOM_ITEMS) begin
            drain_results();
            case (phase % 8)
                3:       thr = THR_MAX;
                6:       thr = THR_AT_RESET;
                0:       thr = THR_MIN;
                default: thr = 8'($urandom_range(1, 3));
            endcase
            write_threshold(thr);
            if (RANDOM_ITEMS - issued_total <= 150) begin
                src_gap_pct = 0;
                stall_pct   = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       src_gap_pct = 0;
                    1:       src_gap_pct = 10;
                    2:       src_gap_pct = 30;
                    default: src_gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            goal = issued_total + ((thr == THR_MAX) ? 40 : 150);
            while (issued_total < goal) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    // clean press then release, select favored
                    b      = $urandom_range(0, 7);
                    s_lvl  = (b <= 3 || b == 7) ? LVL_DN : LVL_UP;
                    e_lvl  = (b >= 4) ? LVL_DN : LVL_UP;
                    settle = (thr == THR_MAX) ? $urandom_range(1, 6)
                                              : int'(thr) + 1 + $urandom_range(0, 2);
                    hold_levels(s_lvl, e_lvl, settle);
                    settle = (thr == THR_MAX) ? $urandom_range(1, 6)
                                              : int'(thr) + 1 + $urandom_range(0, 2);
                    hold_levels(LVL_UP, LVL_UP, settle);
                end else if (r < 80) begin
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        send_request(REQ_TICK, 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'b0, '0);
                    end
                end else if (r < 90) begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        hold_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
                    end
                end else begin
                    // bounce no longer than the threshold
                    n = $urandom_range(1, (thr > 8) ? 8 : int'(thr));
                    b = $urandom_range(0, 2);
                    hold_levels((b != 1) ? LVL_DN : LVL_UP, (b != 0) ? LVL_DN : LVL_UP, n);
                    hold_levels(LVL_UP, LVL_UP, $urandom_range(1, 3));
                end
            end
            phase++;
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("dual_countdown_timer_controller_unit test passed");
        end else begin
            $display("dual_countdown_timer_controller_unit test failed");
        end
        $finish;
    end

endmodule
